### rtl/hcb_pkg.sv
// Shared field widths and controller state type for the Huffman code builder.
package hcb_pkg;

    localparam int LEAF_WEIGHT_W = 16;
    localparam int LEAF_INDEX_W  = 4;
    localparam int CODE_BITS_W   = 15;
    localparam int CODE_LENGTH_W = 4;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 40;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_WR1,
        ST_WR2,
        ST_WR3,
        ST_WALK_ISSUE,
        ST_WALK,
        ST_OUT
    } hcb_state_t;

endpackage

### rtl/hcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/huffman_code_builder_unit.sv
// Huffman code builder: loads leaf weights, builds the tree, streams out per-leaf codes.
//
// Weights are accepted back to back while loading. A transaction with tlast starts the build
// over the n loaded leaves (weights past MAX_LEAVES are dropped). Merge k scans nodes
// 0..n+k-1 through the single read port of the node memories, one node per cycle, then
// passes through a pipeline drain state and three write-back states. Each leaf's code is
// then walked leaf to root, one memory read per tree level, before its result transaction
// is offered. No input is accepted from the start of the build until the final code
// transaction is taken.
module huffman_code_builder_unit #(
    parameter int MAX_LEAVES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hcb_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] leaf_weight
    input  logic                          s_tlast,  // last_leaf
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] leaf_index, [19:4] weight_out, [34:20] code_bits, [38:35] code_length, [39] 0
    output logic [hcb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast   // last_code
);

    import hcb_pkg::*;

    localparam int NODES  = 2 * MAX_LEAVES - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(MAX_LEAVES + 1);
    localparam int LEN_W  = $clog2(MAX_LEAVES);
    localparam int WGT_W  = LEAF_WEIGHT_W + $clog2(MAX_LEAVES);

    hcb_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [NODE_W-1:0]        lim_reg, lim_next;
    logic [NODE_W-1:0]        last_node_reg, last_node_next;
    logic [NODE_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [NODE_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [WGT_W-1:0]         m1_reg, m1_next, m2_reg, m2_next;
    logic [NODE_W-1:0]        x1_reg, x1_next, x2_reg, x2_next;
    logic                     h1_reg, h1_next, h2_reg, h2_next;
    logic [CNT_W-1:0]         leaf_reg, leaf_next;
    logic [NODE_W-1:0]        cur_reg, cur_next, prev_reg, prev_next;
    logic                     first_reg, first_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [CODE_BITS_W-1:0]   code_reg, code_next;
    logic [LEAF_WEIGHT_W-1:0] wout_reg, wout_next;

    logic                     wgt_we, par_we, left_we;
    logic [NODE_W-1:0]        wgt_waddr, par_waddr, left_waddr, raddr;
    logic [WGT_W-1:0]         wgt_wdata, wgt_rdata;
    logic [NODE_W:0]          par_wdata, par_rdata;
    logic [NODE_W-1:0]        left_rdata;

    logic                     s_acc;
    logic                     room;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     par_valid;
    logic [NODE_W-1:0]        par_idx;
    logic                     right_bit;

    hcb_ram #(.WIDTH(WGT_W), .DEPTH(NODES)) u_weight_ram (
        .aclk  (aclk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wgt_wdata),
        .raddr (raddr),
        .rdata (wgt_rdata)
    );

    hcb_ram #(.WIDTH(NODE_W + 1), .DEPTH(NODES)) u_parent_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (raddr),
        .rdata (par_rdata)
    );

    hcb_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_left_ram (
        .aclk  (aclk),
        .we    (left_we),
        .waddr (left_waddr),
        .wdata (x1_reg),
        .raddr (raddr),
        .rdata (left_rdata)
    );

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign room      = (cnt_reg < CNT_W'(MAX_LEAVES));
    assign cnt_inc   = cnt_reg + CNT_W'(room);
    assign par_valid = par_rdata[NODE_W];
    assign par_idx   = par_rdata[NODE_W-1:0];
    assign right_bit = (left_rdata != prev_reg);

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = (leaf_reg == n_reg - CNT_W'(1));
    assign m_tdata  = {1'b0, CODE_LENGTH_W'(len_reg), code_reg, wout_reg,
                       LEAF_INDEX_W'(leaf_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        n_reg         <= n_next;
        lim_reg       <= lim_next;
        last_node_reg <= last_node_next;
        scan_idx_reg  <= scan_idx_next;
        rd_vld_reg    <= rd_vld_next;
        rd_idx_reg    <= rd_idx_next;
        m1_reg        <= m1_next;
        m2_reg        <= m2_next;
        x1_reg        <= x1_next;
        x2_reg        <= x2_next;
        h1_reg        <= h1_next;
        h2_reg        <= h2_next;
        leaf_reg      <= leaf_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        first_reg     <= first_next;
        len_reg       <= len_next;
        code_reg      <= code_next;
        wout_reg      <= wout_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        lim_next       = lim_reg;
        last_node_next = last_node_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = scan_idx_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        leaf_next      = leaf_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        first_next     = first_reg;
        len_next       = len_reg;
        code_next      = code_reg;
        wout_next      = wout_reg;

        wgt_we     = 1'b0;
        wgt_waddr  = lim_reg;
        wgt_wdata  = m1_reg + m2_reg;
        par_we     = 1'b0;
        par_waddr  = lim_reg;
        par_wdata  = {1'b1, lim_reg};
        left_we    = 1'b0;
        left_waddr = lim_reg;
        raddr      = scan_idx_reg;

        // running two-smallest search over returned scan data
        if (rd_vld_reg && !par_valid) begin
            if (!h1_reg || wgt_rdata < m1_reg) begin
                m2_next = m1_reg;
                x2_next = x1_reg;
                h2_next = h1_reg;
                m1_next = wgt_rdata;
                x1_next = rd_idx_reg;
                h1_next = 1'b1;
            end else if (!h2_reg || wgt_rdata < m2_reg) begin
                m2_next = wgt_rdata;
                x2_next = rd_idx_reg;
                h2_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (room) begin
                        wgt_we    = 1'b1;
                        wgt_waddr = NODE_W'(cnt_reg);
                        wgt_wdata = WGT_W'(s_tdata[LEAF_WEIGHT_W-1:0]);
                        par_we    = 1'b1;
                        par_waddr = NODE_W'(cnt_reg);
                        par_wdata = {1'b0, NODE_W'(0)};
                    end
                    cnt_next = cnt_inc;
                    if (s_tlast) begin
                        n_next = cnt_inc;
                        if (cnt_inc == CNT_W'(1)) begin
                            leaf_next  = '0;
                            state_next = ST_WALK_ISSUE;
                        end else begin
                            lim_next       = NODE_W'(cnt_inc);
                            last_node_next = NODE_W'({cnt_inc, 1'b0} - (CNT_W + 1)'(2));
                            scan_idx_next  = '0;
                            h1_next        = 1'b0;
                            h2_next        = 1'b0;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                raddr         = scan_idx_reg;
                rd_vld_next   = 1'b1;
                scan_idx_next = scan_idx_reg + NODE_W'(1);
                if (scan_idx_reg == lim_reg - NODE_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WR1;
            end
            ST_WR1: begin
                par_we     = 1'b1;
                par_waddr  = x1_reg;
                state_next = ST_WR2;
            end
            ST_WR2: begin
                par_we     = 1'b1;
                par_waddr  = x2_reg;
                wgt_we     = 1'b1;
                left_we    = 1'b1;
                state_next = ST_WR3;
            end
            ST_WR3: begin
                par_we    = 1'b1;
                par_wdata = {1'b0, NODE_W'(0)};
                if (lim_reg == last_node_reg) begin
                    leaf_next  = '0;
                    state_next = ST_WALK_ISSUE;
                end else begin
                    lim_next      = lim_reg + NODE_W'(1);
                    scan_idx_next = '0;
                    h1_next       = 1'b0;
                    h2_next       = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_WALK_ISSUE: begin
                raddr      = NODE_W'(leaf_reg);
                cur_next   = NODE_W'(leaf_reg);
                first_next = 1'b1;
                len_next   = '0;
                code_next  = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                raddr      = par_idx;
                first_next = 1'b0;
                if (first_reg) begin
                    wout_next = wgt_rdata[LEAF_WEIGHT_W-1:0];
                end else begin
                    code_next = code_reg | (CODE_BITS_W'(right_bit) << len_reg);
                    len_next  = len_reg + LEN_W'(1);
                end
                if (par_valid) begin
                    prev_next = cur_reg;
                    cur_next  = par_idx;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (m_tlast) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        leaf_next  = leaf_reg + CNT_W'(1);
                        state_next = ST_WALK_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    a_two_found: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WR1 |-> h1_reg && h2_reg && x1_reg != x2_reg)
        else $error("merge without two distinct unparented nodes");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input accepted while a code transaction is pending");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> state_reg == ST_LOAD && cnt_reg == '0)
        else $error("leaf count not cleared after final code");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> scan_idx_reg < lim_reg && lim_reg <= last_node_reg)
        else $error("scan index out of range");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LEAVES))
        else $error("leaf count overflow");

endmodule

### tb/huffman_code_builder_unit_test.sv
// Self-checking stream testbench for the Huffman code builder: random leaf sets, per-leaf codes.
module huffman_code_builder_unit_test;

    import hcb_pkg::*;

    localparam int MAX_LEAVES = 16;
    localparam int NODE_CNT   = 2 * MAX_LEAVES - 1;
    localparam int QUIET_MAX  = 10000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic [LEAF_WEIGHT_W-1:0] weight;
        logic                     last;
        int                       gap;
        bit                       sync;
    } leaf_item_t;

    typedef struct packed {
        logic [LEAF_INDEX_W-1:0]  leaf_index;
        logic [LEAF_WEIGHT_W-1:0] weight;
        logic [CODE_BITS_W-1:0]   code_bits;
        logic [CODE_LENGTH_W-1:0] code_length;
        logic                     last_code;
    } leaf_code_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    leaf_item_t weight_q[$];
    leaf_code_t leaf_codes_q[$];

    logic [LEAF_WEIGHT_W-1:0] leaf_wt [MAX_LEAVES];
    int unsigned              leaf_cnt = 0;

    leaf_item_t cur_item;
    bit         have_item  = 0;
    bit         offering   = 0;
    int         send_gap   = 0;
    int         rcv_gap    = 0;
    int         hold_left  = 0;
    bit         slow_rcv   = 1;
    int         quiet      = 0;
    int         fail_count = 0;
    int         leaves_in  = 0;
    int         sets_in    = 0;
    int         codes_out  = 0;
    int         holds_done = 0;

    huffman_code_builder_unit #(
        .MAX_LEAVES(MAX_LEAVES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Merge the two lightest free nodes until one root is left, then walk each leaf up.
    function automatic void build_codes();
        logic [19:0]              wt     [NODE_CNT];
        logic [4:0]               up     [NODE_CNT];
        logic                     has_up [NODE_CNT];
        logic [4:0]               left   [NODE_CNT];
        int                       n, lim, x1, x2, c, len;
        logic                     h1, h2;
        logic [19:0]              m1, m2;
        logic [CODE_BITS_W-1:0]   code;
        leaf_code_t               exp_code;
        n = leaf_cnt;
        for (int k = 0; k < NODE_CNT; k++) begin
            wt[k]     = (k < n) ? 20'(leaf_wt[k]) : '0;
            up[k]     = '0;
            has_up[k] = 1'b0;
            left[k]   = '0;
        end
        for (int i = 0; i < n - 1; i++) begin
            lim = n + i;
            h1 = 1'b0; h2 = 1'b0; m1 = '0; m2 = '0; x1 = 0; x2 = 0;
            for (int j = 0; j < lim; j++) begin
                if (!has_up[j]) begin
                    if (!h1 || wt[j] < m1) begin
                        m2 = m1; x2 = x1; h2 = h1;
                        m1 = wt[j]; x1 = j; h1 = 1'b1;
                    end else if (!h2 || wt[j] < m2) begin
                        m2 = wt[j]; x2 = j; h2 = 1'b1;
                    end
                end
            end
            up[x1] = 5'(lim); has_up[x1] = 1'b1;
            up[x2] = 5'(lim); has_up[x2] = 1'b1;
            wt[lim]   = wt[x1] + wt[x2];
            left[lim] = 5'(x1);
        end
        for (int i = 0; i < n; i++) begin
            c = i; len = 0; code = '0;
            while (has_up[c]) begin
                if (left[up[c]] != 5'(c) && len < CODE_BITS_W)
                    code[len] = 1'b1;
                len++;
                c = up[c];
            end
            exp_code.leaf_index  = LEAF_INDEX_W'(i);
            exp_code.weight      = leaf_wt[i];
            exp_code.code_bits   = code;
            exp_code.code_length = CODE_LENGTH_W'(len);
            exp_code.last_code   = (i == n - 1);
            leaf_codes_q.push_back(exp_code);
        end
    endfunction

    function automatic void load_leaf(logic [LEAF_WEIGHT_W-1:0] w, logic last);
        if (leaf_cnt < MAX_LEAVES) begin
            leaf_wt[leaf_cnt] = w;
            leaf_cnt++;
            leaves_in++;
        end
        if (last) begin
            build_codes();
            leaf_cnt = 0;
            sets_in++;
        end
    endfunction

    function automatic void check_field(string name, longint expected, longint actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (offering && s_tvalid && s_tready) begin
                load_leaf(s_tdata[LEAF_WEIGHT_W-1:0], s_tlast);
                offering  = 0;
                have_item = 0;
            end
            if (!offering) begin
                if (!have_item && weight_q.size() > 0 &&
                    !(weight_q[0].sync && leaf_codes_q.size() > 0)) begin
                    cur_item  = weight_q.pop_front();
                    have_item = 1;
                    send_gap  = cur_item.gap;
                end
                if (have_item) begin
                    if (send_gap > 0)
                        send_gap--;
                    else
                        offering = 1;
                end
            end
            s_tvalid <= offering;
            s_tdata  <= S_TDATA_W'(cur_item.weight);
            s_tlast  <= cur_item.last;
        end
    end

    // monitor
    always @(posedge aclk) begin
        leaf_code_t exp_code;
        logic       rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                codes_out++;
                if (leaf_codes_q.size() == 0) begin
                    $error("unexpected code transaction: tdata %h tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    exp_code = leaf_codes_q.pop_front();
                    check_field("leaf_index", exp_code.leaf_index, m_tdata[3:0]);
                    check_field("weight_out", exp_code.weight, m_tdata[19:4]);
                    check_field("code_bits", exp_code.code_bits, m_tdata[34:20]);
                    check_field("code_length", exp_code.code_length, m_tdata[38:35]);
                    check_field("tdata_pad", 0, m_tdata[39]);
                    check_field("last_code", exp_code.last_code, m_tlast);
                end
                if ($urandom_range(0, 19) == 0)
                    slow_rcv = !slow_rcv;
                rcv_gap = slow_rcv ? $urandom_range(0, 8) : 0;
                if (codes_out == 40 || codes_out == 260) begin
                    hold_left = LONG_HOLD;
                    holds_done++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic add_leaf(logic [LEAF_WEIGHT_W-1:0] w, logic last, int gap, bit sync);
        leaf_item_t item;
        item.weight = w;
        item.last   = last;
        item.gap    = gap;
        item.sync   = sync;
        weight_q.push_back(item);
    endtask

    initial begin
        int                       counted;
        int                       set_size;
        int                       kind;
        int                       n_sets;
        bit                       bursty;
        logic [LEAF_WEIGHT_W-1:0] w;
        logic [LEAF_WEIGHT_W-1:0] fa, fb;

        // single leaf, max weight
        add_leaf(16'hFFFF, 1'b1, 0, 1'b0);
        // two leaves at the extremes
        add_leaf(16'h0000, 1'b0, 0, 1'b0);
        add_leaf(16'hFFFF, 1'b1, 3, 1'b0);
        // three-way tie, lower index wins
        for (int i = 0; i < 3; i++)
            add_leaf(16'd7, i == 2, 1, 1'b0);
        // Fibonacci weights give the deepest tree: 15-bit codes
        fa = 1; fb = 1;
        for (int i = 0; i < MAX_LEAVES; i++) begin
            add_leaf(fa, i == MAX_LEAVES - 1, $urandom_range(0, 8), 1'b0);
            w = fa + fb; fa = fb; fb = w;
        end

        counted = 22;
        n_sets  = 0;
        while (counted < 440) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                set_size = $urandom_range(MAX_LEAVES + 1, MAX_LEAVES + 4);
            else if (kind == 1)
                set_size = MAX_LEAVES;
            else
                set_size = $urandom_range(1, 12);
            kind   = $urandom_range(0, 3);
            bursty = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_size; i++) begin
                case (kind)
                    0: w = 16'($urandom);
                    1: w = 16'($urandom_range(0, 7));
                    2: w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: w = 16'($urandom_range(0, 255));
                endcase
                add_leaf(w, i == set_size - 1, bursty ? 0 : $urandom_range(0, 8),
                         i == 0 && (n_sets % 12 == 0));
            end
            counted += (set_size > MAX_LEAVES) ? MAX_LEAVES : set_size;
            n_sets++;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (weight_q.size() > 0 || have_item || offering || leaf_codes_q.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        while (leaf_codes_q.size() > 0) begin
            $error("missing code transaction for leaf %0d", leaf_codes_q[0].leaf_index);
            void'(leaf_codes_q.pop_front());
            fail_count++;
        end

        $display("Sent %0d leaf weights in %0d code sets, checked %0d code transactions",
                 leaves_in, sets_in, codes_out);
        $display("Covered single leaf, ties, 15-bit codes, overflow sets, %0d long output holds",
                 holds_done);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/hcb_pkg.sv
rtl/hcb_ram.sv
rtl/huffman_code_builder_unit.sv
tb/huffman_code_builder_unit_test.sv
